>>> src/hsl_pkg.sv
// Package for the HTTP start line parser: character codes, phase encoding, parser
// state, input item and result types, and the version tag. No dependencies.
`timescale 1ns / 1ps

package hsl_pkg;

    localparam int LINE_MAX = 4096;
    localparam int POS_W    = $clog2(LINE_MAX) + 1;
    localparam int OFS_W    = 12;
    localparam int ACC_W    = 20;
    localparam int CODE_W   = 21;
    localparam int MINOR_W  = 4;
    localparam int TAG_W    = 3;

    localparam logic [ACC_W-1:0] CODE_MAX = 20'd1048575;
    localparam logic [TAG_W-1:0] TAG_LEN  = 3'd7;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_HT    = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_H     = 8'h48;

    localparam int TDATA_IN_W  = 8;
    localparam int TDATA_OUT_W = 88;

    typedef enum logic [3:0] {
        PH_SCAN  = 4'd0,
        PH_MINOR = 4'd1,
        PH_AFTER = 4'd2,
        PH_FAIL  = 4'd3,
        PH_RSP   = 4'd4,
        PH_RWS   = 4'd5,
        PH_RSIGN = 4'd6,
        PH_RDIG  = 4'd7,
        PH_RSKIP = 4'd8,
        PH_RREST = 4'd9
    } t_phase;

    typedef struct packed {
        t_phase             phase;
        logic [POS_W-1:0]   pos;
        logic [TAG_W-1:0]   match_k;
        logic               ver_at_zero;
        logic               space_seen;
        logic [OFS_W-1:0]   first_space_pos;
        logic [OFS_W-1:0]   last_nonspace_pos;
        logic [OFS_W-1:0]   url_begin;
        logic [OFS_W-1:0]   status_begin;
        logic [MINOR_W-1:0] minor;
        logic [ACC_W-1:0]   acc;
        logic               neg;
        logic               given;
    } t_state;

    localparam t_state ST_RESET = '{
        phase: PH_SCAN, pos: '0, match_k: '0, ver_at_zero: 1'b0, space_seen: 1'b0,
        first_space_pos: '0, last_nonspace_pos: '0, url_begin: '0, status_begin: '0,
        minor: '0, acc: '0, neg: 1'b0, given: 1'b0
    };

    typedef struct packed {
        logic                     ok;
        logic                     kind;
        logic [MINOR_W-1:0]       minor_version;
        logic signed [CODE_W-1:0] code;
        logic                     spans_present;
        logic [OFS_W-1:0]         method_len;
        logic [OFS_W-1:0]         url_start;
        logic [OFS_W-1:0]         url_len;
        logic [OFS_W-1:0]         status_start;
        logic [OFS_W-1:0]         status_len;
    } t_result;

    typedef struct packed {
        logic       valid;
        logic [7:0] byte_req;
        logic       last;
    } t_in_item;

    function automatic logic [7:0] vtag_char(input logic [TAG_W-1:0] k);
        logic [7:0] ch;
        unique case (k)
            3'd0:    ch = 8'h48;
            3'd1:    ch = 8'h54;
            3'd2:    ch = 8'h54;
            3'd3:    ch = 8'h50;
            3'd4:    ch = 8'h2F;
            3'd5:    ch = 8'h31;
            3'd6:    ch = 8'h2E;
            default: ch = CH_NUL;
        endcase
        return ch;
    endfunction

endpackage

>>> src/http_start_line_parser.sv
// A result is loaded into the result register when the item that ends the line
// leaves the input register. Throughput: one byte item per cycle; the input register
// holds the item, and when it advances the state update and the result register load
// happen together. The input stalls only while a finished result waits at the output.
// Reset is synchronous and active low and returns the parser to the start of a line with no result pending.
// Top level of the start line parser; uses hsl_pkg, hsl_in_reg, hsl_parse_core, hsl_out_reg.
`timescale 1ns / 1ps

module http_start_line_parser
    import hsl_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [TDATA_IN_W-1:0]  i_s_axis_tdata,   // byte_req
    input  logic                   i_s_axis_tlast,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [TDATA_OUT_W-1:0] o_m_axis_tdata,   // ok, minor_version, code,
                                                     // spans_present, method_len,
                                                     // url_start, url_len,
                                                     // status_start, status_len, pad
    output logic                   o_m_axis_tuser    // kind
);

    t_in_item w_item;
    t_result  w_core_res;
    t_result  w_out_res;
    logic     w_core_valid;
    logic     w_out_free;
    logic     w_advance;

    assign w_advance = w_item.valid && w_out_free;

    hsl_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .i_byte    (i_s_axis_tdata),
        .i_last    (i_s_axis_tlast),
        .i_advance (w_advance),
        .o_ready   (o_s_axis_tready),
        .o_item    (w_item)
    );

    hsl_parse_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (w_advance),
        .i_item      (w_item),
        .o_res_valid (w_core_valid),
        .o_res       (w_core_res)
    );

    hsl_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_core_valid),
        .i_res    (w_core_res),
        .i_tready (i_m_axis_tready),
        .o_free   (w_out_free),
        .o_valid  (o_m_axis_tvalid),
        .o_res    (w_out_res)
    );

    assign o_m_axis_tdata = {1'b0, w_out_res.status_len, w_out_res.status_start,
                             w_out_res.url_len, w_out_res.url_start, w_out_res.method_len,
                             w_out_res.spans_present, w_out_res.code,
                             w_out_res.minor_version, w_out_res.ok};
    assign o_m_axis_tuser = w_out_res.kind;

endmodule

>>> src/hsl_in_reg.sv
// Input register of the start line parser: holds one accepted byte item.
// Depends on hsl_pkg.
`timescale 1ns / 1ps

module hsl_in_reg
    import hsl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    input  logic       i_advance,
    output logic       o_ready,
    output t_in_item   o_item
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;

    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
            r_last <= i_last;
        end
    end

    assign o_item = '{valid: r_valid, byte_req: r_byte, last: r_last};

endmodule

>>> src/hsl_parse_core.sv
// Parser state and per-byte update logic of the start line parser.
// Depends on hsl_pkg.
`timescale 1ns / 1ps

module hsl_parse_core
    import hsl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_advance,
    input  t_in_item i_item,
    output logic     o_res_valid,
    output t_result  o_res
);

    t_state  r_st;
    t_state  n_st;
    t_state  w_take;
    t_state  w_fin_st;
    logic [POS_W-1:0] w_fin_end;
    logic    w_line_end;
    logic    w_overlong;
    t_result w_fin;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_lws(input logic [7:0] c);
        return (c == CH_SP) || (c == CH_HT) || (c == CH_VT) || (c == CH_FF);
    endfunction

    function automatic logic [ACC_W-1:0] accumulate(input logic [ACC_W-1:0] acc,
                                                    input logic [7:0] c);
        logic [ACC_W+3:0] v;
        v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{(ACC_W){1'b0}}, c[3:0]};
        return (v > {4'b0000, CODE_MAX}) ? CODE_MAX : v[ACC_W-1:0];
    endfunction

    function automatic t_state take_byte(input t_state s, input logic [7:0] c);
        t_state           t;
        logic [OFS_W-1:0] p;
        logic [TAG_W-1:0] nk;
        logic [TAG_W-1:0] k1;
        logic             done;
        t    = s;
        p    = s.pos[OFS_W-1:0];
        k1   = s.match_k + 3'd1;
        done = 1'b0;
        nk   = '0;
        case (s.phase)
            PH_SCAN: begin
                if (c == vtag_char(s.match_k)) begin
                    nk = k1;
                end else if (c == CH_H) begin
                    nk = 3'd1;
                end else begin
                    nk = 3'd0;
                end
                if (c == CH_SP) begin
                    if (!s.space_seen) begin
                        t.space_seen      = 1'b1;
                        t.first_space_pos = p;
                    end
                end else if (s.space_seen && s.url_begin == '0) begin
                    t.url_begin = p;
                end
                if (nk != k1) begin
                    if (s.match_k != '0) begin
                        t.last_nonspace_pos = p - 12'd1;
                    end
                    if (nk == '0 && c != CH_SP) begin
                        t.last_nonspace_pos = p;
                    end
                end
                if (nk == TAG_LEN) begin
                    t.ver_at_zero = (p == 12'd6);
                    t.match_k     = '0;
                    t.phase       = PH_MINOR;
                end else begin
                    t.match_k = nk;
                end
            end
            PH_MINOR: begin
                if (is_digit(c)) begin
                    t.minor = c[3:0];
                    t.phase = PH_AFTER;
                end else begin
                    t.phase = PH_FAIL;
                end
            end
            PH_AFTER: begin
                t.phase = (is_lws(c) && s.ver_at_zero) ? PH_RSP : PH_FAIL;
            end
            default: begin
                if (t.phase == PH_RSP) begin
                    if (c == CH_SP) begin
                        done = 1'b1;
                    end else begin
                        t.status_begin = p;
                        t.phase        = PH_RWS;
                    end
                end
                if (!done && t.phase == PH_RWS) begin
                    done = 1'b1;
                    if (!is_lws(c)) begin
                        if (c == CH_PLUS || c == CH_MINUS) begin
                            t.neg   = (c == CH_MINUS);
                            t.phase = PH_RSIGN;
                        end else if (is_digit(c)) begin
                            t.acc   = accumulate(t.acc, c);
                            t.phase = PH_RDIG;
                        end else begin
                            t.phase = PH_RREST;
                        end
                    end
                end
                if (!done && t.phase == PH_RSIGN) begin
                    done = 1'b1;
                    if (is_digit(c)) begin
                        t.acc   = accumulate(t.acc, c);
                        t.phase = PH_RDIG;
                    end else begin
                        t.neg   = 1'b0;
                        t.phase = PH_RREST;
                    end
                end
                if (!done && t.phase == PH_RDIG) begin
                    if (is_digit(c)) begin
                        t.acc = accumulate(t.acc, c);
                        done  = 1'b1;
                    end else begin
                        t.phase = PH_RSKIP;
                    end
                end
                if (!done && t.phase == PH_RSKIP) begin
                    if (c != CH_SP) begin
                        t.status_begin = p;
                        t.phase        = PH_RREST;
                    end
                end
            end
        endcase
        t.pos = s.pos + {{(POS_W-1){1'b0}}, 1'b1};
        return t;
    endfunction

    function automatic t_result finish(input t_state s, input logic [POS_W-1:0] e);
        t_result                  r;
        logic [OFS_W-1:0]         e12;
        logic signed [CODE_W-1:0] cv;
        logic [CODE_W-1:0]        mag;
        r   = '0;
        e12 = e[OFS_W-1:0];
        mag = {1'b0, s.acc};
        cv  = s.neg ? (~mag + 21'd1) : mag;
        case (s.phase)
            PH_AFTER: begin
                if (s.ver_at_zero) begin
                    r.ok            = 1'b1;
                    r.kind          = 1'b1;
                    r.minor_version = s.minor;
                end else if (!s.space_seen) begin
                    r.ok            = 1'b1;
                    r.minor_version = s.minor;
                end else if (s.last_nonspace_pos > s.first_space_pos &&
                             s.url_begin != '0) begin
                    r.ok            = 1'b1;
                    r.minor_version = s.minor;
                    r.spans_present = 1'b1;
                    r.method_len    = s.first_space_pos;
                    r.url_start     = s.url_begin;
                    r.url_len       = s.last_nonspace_pos + 12'd1 - s.url_begin;
                end
            end
            PH_RSP: begin
                r.ok            = 1'b1;
                r.kind          = 1'b1;
                r.minor_version = s.minor;
            end
            PH_RWS, PH_RSIGN: begin
                r.ok            = 1'b1;
                r.kind          = 1'b1;
                r.minor_version = s.minor;
                r.spans_present = 1'b1;
                r.status_start  = s.status_begin;
                r.status_len    = e12 - s.status_begin;
            end
            PH_RDIG: begin
                r.ok            = 1'b1;
                r.kind          = 1'b1;
                r.minor_version = s.minor;
                r.code          = cv;
            end
            PH_RSKIP: begin
                r.ok            = 1'b1;
                r.kind          = 1'b1;
                r.minor_version = s.minor;
                r.code          = cv;
                r.spans_present = 1'b1;
                r.status_start  = e12;
            end
            PH_RREST: begin
                r.ok            = 1'b1;
                r.kind          = 1'b1;
                r.minor_version = s.minor;
                r.code          = cv;
                r.spans_present = 1'b1;
                r.status_start  = s.status_begin;
                r.status_len    = e12 - s.status_begin;
            end
            default: begin
                r = '0;
            end
        endcase
        return r;
    endfunction

    assign w_line_end = (i_item.byte_req == CH_NUL) || (i_item.byte_req == CH_CR) ||
                        (i_item.byte_req == CH_LF);
    assign w_overlong = r_st.pos[POS_W-1];
    assign w_take     = take_byte(r_st, i_item.byte_req);
    assign w_fin_st   = w_line_end ? r_st : w_take;
    assign w_fin_end  = w_line_end ? r_st.pos : w_take.pos;
    assign w_fin      = finish(w_fin_st, w_fin_end);

    always_comb begin
        n_st        = r_st;
        o_res_valid = 1'b0;
        o_res       = w_fin;
        if (i_advance) begin
            if (r_st.given) begin
                if (i_item.last) begin
                    n_st = ST_RESET;
                end
            end else begin
                if (w_line_end) begin
                    o_res_valid = 1'b1;
                end else if (w_overlong) begin
                    o_res_valid = 1'b1;
                    o_res       = '0;
                end else begin
                    n_st        = w_take;
                    o_res_valid = i_item.last;
                end
                if (i_item.last) begin
                    n_st = ST_RESET;
                end else if (o_res_valid) begin
                    n_st.given = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_RESET;
        end else begin
            r_st <= n_st;
        end
    end

endmodule

>>> src/hsl_out_reg.sv
// Result register of the start line parser, drives the output stream.
// Depends on hsl_pkg.
`timescale 1ns / 1ps

module hsl_out_reg
    import hsl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_tready,
    output logic    o_free,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_free  = !r_valid || i_tready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

>>> tb/http_start_line_parser_tb.sv
// Self-checking testbench for http_start_line_parser: streams header text one byte
// per item, predicts each start-line result in its own model and compares it.
// Depends on hsl_pkg and the parser RTL only.
`timescale 1ns / 1ps

module http_start_line_parser_tb;
    import hsl_pkg::*;

    localparam int          RANDOM_BYTES = 250;
    localparam int unsigned CYCLE_LIMIT  = 500_000;
    localparam logic [55:0] VER_TAG      = "HTTP/1.";

    typedef enum int {END_NONE, END_CR, END_LF, END_NUL, END_CRLF} t_line_end;

    typedef struct packed {
        logic       hold;
        logic       last;
        logic [7:0] value;
    } t_text_byte;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [TDATA_IN_W-1:0]  i_s_axis_tdata = '0;    // byte_req
    logic                   i_s_axis_tlast = 1'b0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] o_m_axis_tdata;         // ok, minor_version, code,
                                                    // spans_present, method_len,
                                                    // url_start, url_len,
                                                    // status_start, status_len, pad
    logic                   o_m_axis_tuser;         // kind

    http_start_line_parser u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #10 i_clk = ~i_clk;

    t_text_byte  byte_stream[$];
    logic [7:0]  line_buf[$];
    t_result     pending_results[$];

    int unsigned cycle_count = 0;
    int unsigned mismatch_count = 0;
    int unsigned bytes_sent = 0;
    int unsigned requests_seen = 0;
    int unsigned responses_seen = 0;
    int unsigned rejects_seen = 0;
    int          rand_bytes = 0;

    logic        in_taken = 1'b0;
    logic        out_taken = 1'b0;
    int          send_gap = 0;
    int          recv_stall = 0;
    bit          send_burst = 1'b0;
    bit          recv_burst = 1'b0;
    logic        nxt_valid;
    t_text_byte  cur_byte;

    // Parser model state.
    t_phase      ph;
    int unsigned pos, ver_start, first_sp, last_nonsp, url_b, stat_b, acc, tag_k;
    logic [3:0]  minor;
    bit          sp_seen, neg, given;

    task automatic parser_clear();
        ph = PH_SCAN;
        pos = 0; ver_start = 0; first_sp = 0; last_nonsp = 0;
        url_b = 0; stat_b = 0; acc = 0; tag_k = 0;
        minor = '0; sp_seen = 0; neg = 0; given = 0;
    endtask

    function automatic bit is_digit(input logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic bit is_lws(input logic [7:0] c);
        return c == CH_SP || c == CH_HT || c == CH_VT || c == CH_FF;
    endfunction

    task automatic add_digit(input logic [7:0] c);
        int unsigned v;
        v = acc * 10 + (c - CH_0);
        acc = (v > 1048575) ? 1048575 : v;
    endtask

    function automatic t_result line_result(input int unsigned end_pos);
        t_result r;
        int      v;
        r = '0;
        v = neg ? -int'(acc) : int'(acc);
        r.minor_version = minor;
        r.ok = 1'b1;
        r.kind = 1'b1;
        case (ph)
            PH_AFTER: begin
                if (ver_start != 0) begin
                    r.kind = 1'b0;
                    if (sp_seen) begin
                        if (last_nonsp > first_sp && url_b != 0) begin
                            r.spans_present = 1'b1;
                            r.method_len = 12'(first_sp);
                            r.url_start = 12'(url_b);
                            r.url_len = 12'(last_nonsp + 1 - url_b);
                        end else begin
                            r = '0;
                        end
                    end
                end
            end
            PH_RSP: ;
            PH_RWS, PH_RSIGN: begin
                r.spans_present = 1'b1;
                r.status_start = 12'(stat_b);
                r.status_len = 12'(end_pos - stat_b);
            end
            PH_RDIG: r.code = 21'(v);
            PH_RSKIP: begin
                r.code = 21'(v);
                r.spans_present = 1'b1;
                r.status_start = 12'(end_pos);
            end
            PH_RREST: begin
                r.code = 21'(v);
                r.spans_present = 1'b1;
                r.status_start = 12'(stat_b);
                r.status_len = 12'(end_pos - stat_b);
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    task automatic scan_for_version(input logic [7:0] c);
        int unsigned nk;
        nk = (c == VER_TAG[55 - 8 * tag_k -: 8]) ? tag_k + 1 : ((c == CH_H) ? 1 : 0);
        if (c == CH_SP) begin
            if (!sp_seen) begin
                sp_seen = 1;
                first_sp = pos;
            end
        end else if (sp_seen && url_b == 0) begin
            url_b = pos;
        end
        if (nk != tag_k + 1) begin
            if (tag_k > 0) last_nonsp = pos - 1;
            if (nk == 0 && c != CH_SP) last_nonsp = pos;
        end
        if (nk == 7) begin
            ver_start = pos - 6;
            tag_k = 0;
            ph = PH_MINOR;
        end else begin
            tag_k = nk;
        end
    endtask

    task automatic consume_byte(input logic [7:0] c);
        bit done;
        done = 0;
        case (ph)
            PH_SCAN: scan_for_version(c);
            PH_MINOR: begin
                if (is_digit(c)) begin
                    minor = 4'(c - CH_0);
                    ph = PH_AFTER;
                end else begin
                    ph = PH_FAIL;
                end
            end
            PH_AFTER: ph = (is_lws(c) && ver_start == 0) ? PH_RSP : PH_FAIL;
            default: begin
                // The response phases fall through into one another on the same byte.
                if (ph == PH_RSP) begin
                    if (c == CH_SP) begin
                        done = 1;
                    end else begin
                        stat_b = pos;
                        ph = PH_RWS;
                    end
                end
                if (!done && ph == PH_RWS) begin
                    done = 1;
                    if (c == CH_PLUS || c == CH_MINUS) begin
                        neg = (c == CH_MINUS);
                        ph = PH_RSIGN;
                    end else if (is_digit(c)) begin
                        add_digit(c);
                        ph = PH_RDIG;
                    end else if (!is_lws(c)) begin
                        ph = PH_RREST;
                    end
                end
                if (!done && ph == PH_RSIGN) begin
                    done = 1;
                    if (is_digit(c)) begin
                        add_digit(c);
                        ph = PH_RDIG;
                    end else begin
                        neg = 0;
                        ph = PH_RREST;
                    end
                end
                if (!done && ph == PH_RDIG) begin
                    if (is_digit(c)) begin
                        add_digit(c);
                        done = 1;
                    end else begin
                        ph = PH_RSKIP;
                    end
                end
                if (!done && ph == PH_RSKIP && c != CH_SP) begin
                    stat_b = pos;
                    ph = PH_RREST;
                end
            end
        endcase
    endtask

    task automatic parse_byte(input logic [7:0] c, input logic lst);
        t_result r;
        bit      have;
        have = 0;
        r = '0;
        if (!given) begin
            if (c == CH_NUL || c == CH_CR || c == CH_LF) begin
                r = line_result(pos);
                have = 1;
            end else if (pos >= LINE_MAX) begin
                have = 1;
            end else begin
                consume_byte(c);
                pos++;
                if (lst) begin
                    r = line_result(pos);
                    have = 1;
                end
            end
            if (have) begin
                pending_results.push_back(r);
                given = 1;
            end
        end
        if (lst) parser_clear();
    endtask

    task automatic check_field(input string name, input int e, input int a);
        if (e != a) begin
            $error("%s: expected %0d, got %0d", name, e, a);
            mismatch_count++;
        end
    endtask

    task automatic check_line_result(input logic [TDATA_OUT_W-1:0] d, input logic k);
        t_result got, want;
        got.ok = d[0];
        got.minor_version = d[4:1];
        got.code = d[25:5];
        got.spans_present = d[26];
        got.method_len = d[38:27];
        got.url_start = d[50:39];
        got.url_len = d[62:51];
        got.status_start = d[74:63];
        got.status_len = d[86:75];
        got.kind = k;
        if (pending_results.size() == 0) begin
            $error("result item arrived with no line result pending");
            mismatch_count++;
        end else begin
            want = pending_results.pop_front();
            check_field("ok", want.ok, got.ok);
            check_field("kind", want.kind, got.kind);
            check_field("minor_version", want.minor_version, got.minor_version);
            check_field("code", int'(want.code), int'(got.code));
            check_field("spans_present", want.spans_present, got.spans_present);
            check_field("method_len", want.method_len, got.method_len);
            check_field("url_start", want.url_start, got.url_start);
            check_field("url_len", want.url_len, got.url_len);
            check_field("status_start", want.status_start, got.status_start);
            check_field("status_len", want.status_len, got.status_len);
            if (!want.ok) rejects_seen++;
            else if (want.kind) responses_seen++;
            else requests_seen++;
        end
    endtask

    task automatic draw_wait(inout bit burst, output int n);
        if ($urandom_range(0, 39) == 0) burst = ~burst;
        n = burst ? 0 : $urandom_range(0, 4);
    endtask

    // Result monitor and input predictor; the result is checked before the new byte
    // is predicted so that a stray result never meets a fresh expectation.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            in_taken <= i_s_axis_tvalid && o_s_axis_tready;
            out_taken <= o_m_axis_tvalid && i_m_axis_tready;
            if (i_rst_n) begin
                if (o_m_axis_tvalid && i_m_axis_tready)
                    check_line_result(o_m_axis_tdata, o_m_axis_tuser);
                if (i_s_axis_tvalid && o_s_axis_tready)
                    parse_byte(i_s_axis_tdata, i_s_axis_tlast);
            end
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && (!i_s_axis_tvalid || in_taken)) begin
            nxt_valid = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
            end else if (byte_stream.size() > 0 &&
                         !(byte_stream[0].hold && pending_results.size() > 0)) begin
                cur_byte = byte_stream.pop_front();
                i_s_axis_tdata <= cur_byte.value;
                i_s_axis_tlast <= cur_byte.last;
                nxt_valid = 1'b1;
                bytes_sent++;
                draw_wait(send_burst, send_gap);
            end
            i_s_axis_tvalid <= nxt_valid;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (out_taken) draw_wait(recv_burst, recv_stall);
            if (recv_stall > 0) begin
                recv_stall--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic put_ch(input logic [7:0] c);
        line_buf.push_back(c);
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    endtask

    task automatic put_rand(input int n, input int lo, input int hi);
        for (int i = 0; i < n; i++) line_buf.push_back(8'($urandom_range(hi, lo)));
    endtask

    task automatic put_end(input t_line_end e);
        case (e)
            END_CR:   put_ch(CH_CR);
            END_LF:   put_ch(CH_LF);
            END_NUL:  put_ch(CH_NUL);
            END_CRLF: begin
                put_ch(CH_CR);
                put_ch(CH_LF);
            end
            default: ;
        endcase
    endtask

    // Moves the assembled text into the byte stream, marking its final byte as last.
    task automatic flush_text(input bit hold);
        t_text_byte tb_byte;
        for (int i = 0; i < line_buf.size(); i++) begin
            tb_byte.value = line_buf[i];
            tb_byte.last = (i == line_buf.size() - 1);
            tb_byte.hold = hold && (i == 0);
            byte_stream.push_back(tb_byte);
        end
        line_buf.delete();
    endtask

    task automatic add_line(input string s, input t_line_end e);
        put_str(s);
        put_end(e);
        flush_text(1'b0);
    endtask

    task automatic put_version();
        put_str("HTTP/1.");
        put_ch(8'($urandom_range(CH_9, CH_0)));
    endtask

    task automatic build_request();
        put_rand($urandom_range(1, 6), 8'h41, 8'h5A);
        repeat ($urandom_range(0, 2)) put_ch(CH_SP);
        put_ch(8'h2F);
        put_rand($urandom_range(0, 12), 8'h21, 8'h7E);
        repeat ($urandom_range(0, 3)) put_ch(CH_SP);
        put_version();
    endtask

    task automatic build_response();
        int n;
        put_version();
        case ($urandom_range(0, 5))
            0: put_ch(CH_HT);
            1: put_ch(CH_VT);
            2: put_ch(CH_FF);
            default: put_ch(CH_SP);
        endcase
        repeat ($urandom_range(0, 2)) put_ch(CH_SP);
        case ($urandom_range(0, 3))
            0: put_ch(CH_PLUS);
            1: put_ch(CH_MINUS);
            default: ;
        endcase
        n = ($urandom_range(0, 9) == 0) ? 8 : $urandom_range(0, 4);
        put_rand(n, CH_0, CH_9);
        repeat ($urandom_range(0, 2)) put_ch(CH_SP);
        put_rand($urandom_range(0, 10), 8'h21, 8'h7E);
    endtask

    task automatic make_random_text();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
            build_request();
        end else if (sel < 75) begin
            build_response();
        end else if (sel < 85) begin
            if (sel[0]) build_request();
            else build_response();
            line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
        end else begin
            put_rand($urandom_range(1, 16), 0, 255);
        end
        put_end(t_line_end'($urandom_range(END_NONE, END_CRLF)));
        if ($urandom_range(0, 3) == 0) put_rand($urandom_range(1, 8), 0, 255);
        rand_bytes += line_buf.size();
        flush_text($urandom_range(0, 49) == 0);
    endtask

    initial begin
        parser_clear();

        put_str("GET /index.html HTTP/1.1");
        put_end(END_CRLF);
        put_str("Host: x");
        flush_text(1'b0);
        add_line("HTTP/1.0 200 OK", END_CR);
        add_line("HTTP/1.1 -404 Not Found", END_NONE);
        add_line("HTTP/1.1 +99999999 Big", END_LF);
        add_line("HTTP/1.1 -9999999", END_CR);
        add_line("HTTP/1.1\t \tabc", END_LF);
        add_line("HTTP/1.1", END_NONE);
        add_line("HTTP/1.1 ", END_NUL);
        add_line("HTTP/1.1 200   ", END_CR);
        add_line("HTTP/1.1 -x", END_CR);
        add_line("HTTP/1.1 -", END_CR);
        add_line("", END_CRLF);
        add_line("", END_NUL);
        add_line("no version here", END_LF);
        add_line("HTTP/1.x 200", END_CR);
        add_line("HTTP/1.12", END_CR);
        add_line("GET / HTTP/1.1 extra", END_CR);
        add_line("GETHTTP/1.0", END_CR);
        add_line("GET    HTTP/1.1", END_CR);
        add_line("GET  /a b  HTTP/1.1", END_LF);
        add_line("xHHTTP/1.5", END_NONE);
        add_line("GET HTHTTP/1.1", END_CR);
        add_line("HTTP/1.9 abc", END_CR);
        add_line("HTTP/1.1\v007 ok", END_NONE);
        add_line("HTTP/1.3\f", END_NONE);
        put_ch(8'hFF);
        put_ch(8'h80);
        put_end(END_LF);
        flush_text(1'b0);

        // The sender waits here until every earlier result has drained.
        put_str("HTTP/1.1 200 OK");
        put_end(END_CRLF);
        flush_text(1'b1);

        while (rand_bytes < RANDOM_BYTES) make_random_text();

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (byte_stream.size() != 0 || i_s_axis_tvalid || pending_results.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (pending_results.size() != 0) begin
            $error("%0d line results never arrived", pending_results.size());
            mismatch_count++;
        end
        $display("Sent %0d byte items; checked %0d requests, %0d responses, %0d rejected lines.",
                 bytes_sent, requests_seen, responses_seen, rejects_seen);
        $display("Both stream sides idled at random, and the sender once drained all results.");
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
